>>> hdl/rlsg_pkg.sv
// ============================================================================
// rlsg_pkg
// Shared constants and types of the radial lens shading grid.
// ============================================================================
package rlsg_pkg;

   localparam int GRID_WIDTH_DEFAULT  = 52;
   localparam int GRID_HEIGHT_DEFAULT = 39;

   localparam int COORD_W      = 6;
   localparam int GAIN_W       = 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 25;
   localparam int NUM_CHANNELS = 3;
   localparam int DIST_W       = 8;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_RED_SHADING   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN_SHADING = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_SHADING  = 2'd2;

   localparam logic [CSR_DATA_W-1:0] SHADING_RESET = 25'd64;
   localparam logic [GAIN_W-1:0]     GAIN_MAX      = 8'd255;

   typedef struct packed {
      logic signed [8:0] strength;
      logic [7:0]        radius;
      logic [7:0]        base;
   } shading_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctrl_type;

endpackage

>>> hdl/rlsg_if.sv
// ============================================================================
// rlsg_if
// Channel interfaces of the radial lens shading grid.
// ============================================================================
interface rlsg_req_if;
   logic                         valid;
   logic                         ready;
   logic [rlsg_pkg::COORD_W-1:0] cell_col;
   logic [rlsg_pkg::COORD_W-1:0] cell_row;

   modport source (output valid, output cell_col, output cell_row, input ready);
   modport sink (input valid, input cell_col, input cell_row, output ready);
endinterface

interface rlsg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rlsg_pkg::GAIN_W-1:0] red_gain;
   logic [rlsg_pkg::GAIN_W-1:0] green_gain;
   logic [rlsg_pkg::GAIN_W-1:0] blue_gain;

   modport source (output valid, output red_gain, output green_gain, output blue_gain,
                   input ready);
   modport sink (input valid, input red_gain, input green_gain, input blue_gain,
                 output ready);
endinterface

interface rlsg_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rlsg_pkg::CSR_INDEX_W-1:0] index;
   logic [rlsg_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/radial_lens_shading_grid.sv
// ============================================================================
// radial_lens_shading_grid
// Red, green and blue lens shading gains for one cell of the shading grid.
//
// Channel  Dir  Payload                             Beat accepted when
// req_if   in   cell_col, cell_row                  valid && ready
// rsp_if   out  red_gain, green_gain, blue_gain     valid && ready
// csr_if   in   index, data (shading register)      valid && ready (always ready)
//
// One cell enters per cycle unless a stalled result holds the pipeline.
// The pipeline holds the square root (four stages) and the divide by the
// radius (three stages).
// Reset clears all pipeline valid bits and loads 64 into each shading register.
// A stalled result holds the whole pipeline; req_if.ready drops only then.
// ============================================================================
module radial_lens_shading_grid #(
   parameter int GRID_WIDTH  = rlsg_pkg::GRID_WIDTH_DEFAULT,
   parameter int GRID_HEIGHT = rlsg_pkg::GRID_HEIGHT_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   rlsg_req_if.sink    req_if,
   rlsg_rsp_if.source  rsp_if,
   rlsg_csr_if.sink    csr_if
);

   rlsg_pkg::shading_type [rlsg_pkg::NUM_CHANNELS-1:0] shading_ff;
   rlsg_pkg::shading_type [rlsg_pkg::NUM_CHANNELS-1:0] shading_in;

   logic                                                   advance;
   logic                                                   out_valid;
   logic                                                   dist_valid;
   logic [rlsg_pkg::DIST_W-1:0]                            distance;
   logic [rlsg_pkg::NUM_CHANNELS-1:0][rlsg_pkg::GAIN_W-1:0] gain;
   rlsg_pkg::pipe_ctrl_type                                dist_ctrl;
   rlsg_pkg::pipe_ctrl_type                                gain_ctrl;

   always_comb begin
      shading_in = shading_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            rlsg_pkg::CSR_RED_SHADING: begin
               shading_in[rlsg_pkg::CH_RED] = rlsg_pkg::shading_type'(csr_if.data);
            end
            rlsg_pkg::CSR_GREEN_SHADING: begin
               shading_in[rlsg_pkg::CH_GREEN] = rlsg_pkg::shading_type'(csr_if.data);
            end
            rlsg_pkg::CSR_BLUE_SHADING: begin
               shading_in[rlsg_pkg::CH_BLUE] = rlsg_pkg::shading_type'(csr_if.data);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < rlsg_pkg::NUM_CHANNELS; c++) begin
            shading_ff[c] <= rlsg_pkg::shading_type'(rlsg_pkg::SHADING_RESET);
         end
      end else begin
         shading_ff <= shading_in;
      end
   end

   assign csr_if.ready = 1'b1;

   assign advance      = !out_valid || rsp_if.ready;
   assign req_if.ready = advance;
   assign dist_ctrl    = '{advance: advance, valid: req_if.valid};
   assign gain_ctrl    = '{advance: advance, valid: dist_valid};

   rlsg_dist #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (dist_ctrl),
      .cell_col   (req_if.cell_col),
      .cell_row   (req_if.cell_row),
      .dist_valid (dist_valid),
      .distance   (distance)
   );

   rlsg_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (gain_ctrl),
      .distance  (distance),
      .shading   (shading_ff),
      .out_valid (out_valid),
      .gain      (gain)
   );

   assign rsp_if.valid      = out_valid;
   assign rsp_if.red_gain   = gain[rlsg_pkg::CH_RED];
   assign rsp_if.green_gain = gain[rlsg_pkg::CH_GREEN];
   assign rsp_if.blue_gain  = gain[rlsg_pkg::CH_BLUE];

endmodule

>>> hdl/rlsg_dist.sv
// ============================================================================
// rlsg_dist
// Distance pipeline: squared offsets from the grid center, then a floor
// square root resolved two bits per stage.
// ============================================================================
module rlsg_dist #(
   parameter int GRID_WIDTH  = rlsg_pkg::GRID_WIDTH_DEFAULT,
   parameter int GRID_HEIGHT = rlsg_pkg::GRID_HEIGHT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rlsg_pkg::pipe_ctrl_type         ctrl,
   input  logic [rlsg_pkg::COORD_W-1:0]    cell_col,
   input  logic [rlsg_pkg::COORD_W-1:0]    cell_row,
   output logic                            dist_valid,
   output logic [rlsg_pkg::DIST_W-1:0]     distance
);

   localparam int DX_W        = 9;
   localparam int DX_SQ_W     = 15;
   localparam int SQ_W        = 16;
   localparam int SQRT_STAGES = 4;
   localparam int SQRT_STEPS  = 2;
   localparam int NUM_STAGES  = SQRT_STAGES + 2;

   localparam logic signed [DX_W-1:0] COL_CENTER = DX_W'(GRID_WIDTH / 2);
   localparam logic signed [DX_W-1:0] ROW_CENTER = DX_W'(GRID_HEIGHT / 2);

   typedef struct packed {
      logic [8:0]                     rem;
      logic [rlsg_pkg::DIST_W-1:0]    root;
   } sqrt_state_type;

   function automatic sqrt_state_type sqrt_step(input sqrt_state_type s,
                                                input logic [1:0] pair);
      logic [10:0]    rem_sh;
      logic [10:0]    trial;
      sqrt_state_type r;
      rem_sh = {s.rem, pair};
      trial  = {1'b0, s.root, 2'b01};
      if (rem_sh >= trial) begin
         r.rem  = 9'(rem_sh - trial);
         r.root = {s.root[6:0], 1'b1};
      end else begin
         r.rem  = rem_sh[8:0];
         r.root = {s.root[6:0], 1'b0};
      end
      return r;
   endfunction

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [DX_SQ_W-1:0]    dx_sq_ff;
   logic [DX_SQ_W-1:0]    dx_sq_in;
   logic [DX_SQ_W-1:0]    dy_sq_ff;
   logic [DX_SQ_W-1:0]    dy_sq_in;
   logic [SQ_W-1:0]       sum_ff;
   logic [SQ_W-1:0]       sum_in;
   sqrt_state_type        sqrt_ff [SQRT_STAGES];
   sqrt_state_type        sqrt_in [SQRT_STAGES];
   logic [SQ_W-1:0]       n_ff [SQRT_STAGES];
   logic [SQ_W-1:0]       n_in [SQRT_STAGES];

   always_comb begin : p_square
      logic signed [DX_W-1:0]     dx;
      logic signed [DX_W-1:0]     dy;
      logic signed [2*DX_W-1:0]   dx_sq;
      logic signed [2*DX_W-1:0]   dy_sq;
      dx       = $signed({{(DX_W-rlsg_pkg::COORD_W){1'b0}}, cell_col}) - COL_CENTER;
      dy       = $signed({{(DX_W-rlsg_pkg::COORD_W){1'b0}}, cell_row}) - ROW_CENTER;
      dx_sq    = dx * dx;
      dy_sq    = dy * dy;
      dx_sq_in = dx_sq[DX_SQ_W-1:0];
      dy_sq_in = dy_sq[DX_SQ_W-1:0];
      sum_in   = {1'b0, dx_sq_ff} + {1'b0, dy_sq_ff};
      valid_in = {valid_ff[NUM_STAGES-2:0], ctrl.valid};
   end

   always_comb begin : p_sqrt
      sqrt_state_type s;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (k == 0) begin
            s       = '0;
            n_in[k] = sum_ff;
         end else begin
            s       = sqrt_ff[k-1];
            n_in[k] = n_ff[k-1];
         end
         for (int j = 0; j < SQRT_STEPS; j++) begin
            s = sqrt_step(s, n_in[k][SQ_W-2-2*(k*SQRT_STEPS+j) +: 2]);
         end
         sqrt_in[k] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl.advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         dx_sq_ff <= dx_sq_in;
         dy_sq_ff <= dy_sq_in;
         sum_ff   <= sum_in;
         for (int k = 0; k < SQRT_STAGES; k++) begin
            sqrt_ff[k] <= sqrt_in[k];
            n_ff[k]    <= n_in[k];
         end
      end
   end

   assign dist_valid = valid_ff[NUM_STAGES-1];
   assign distance   = sqrt_ff[SQRT_STAGES-1].root;

   a_root_bounds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NUM_STAGES-1] |->
         ((17'(distance) * 17'(distance)) <= 17'(n_ff[SQRT_STAGES-1])) &&
         (((17'(distance) + 17'd1) * (17'(distance) + 17'd1)) >
          17'(n_ff[SQRT_STAGES-1])))
      else $error("square root result out of bounds");

endmodule

>>> hdl/rlsg_gain.sv
// ============================================================================
// rlsg_gain
// Gain pipeline for all color channels: falloff product, a restoring divide
// by the radius over three stages, then sign, base offset and clamping.
// ============================================================================
module rlsg_gain (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  rlsg_pkg::pipe_ctrl_type                               ctrl,
   input  logic [rlsg_pkg::DIST_W-1:0]                           distance,
   input  rlsg_pkg::shading_type [rlsg_pkg::NUM_CHANNELS-1:0]    shading,
   output logic                                                  out_valid,
   output logic [rlsg_pkg::NUM_CHANNELS-1:0][rlsg_pkg::GAIN_W-1:0] gain
);

   localparam int NCH        = rlsg_pkg::NUM_CHANNELS;
   localparam int MAG_W      = 16;
   localparam int QUOT_W     = 9;
   localparam int DIV_STAGES = 3;
   localparam int DIV_STEPS  = QUOT_W / DIV_STAGES;
   localparam int NUM_STAGES = DIV_STAGES + 2;
   localparam int SUM_W      = 11;

   typedef struct packed {
      logic [7:0]        rem;
      logic [QUOT_W-1:0] quot;
   } div_state_type;

   function automatic div_state_type div_step(input div_state_type s, input logic bit_in,
                                              input logic [7:0] divisor);
      logic [8:0]    rem_sh;
      div_state_type r;
      rem_sh = {s.rem, bit_in};
      if (rem_sh >= {1'b0, divisor}) begin
         r.rem  = 8'(rem_sh - {1'b0, divisor});
         r.quot = {s.quot[QUOT_W-2:0], 1'b1};
      end else begin
         r.rem  = rem_sh[7:0];
         r.quot = {s.quot[QUOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   logic [NUM_STAGES-1:0]          valid_ff;
   logic [NUM_STAGES-1:0]          valid_in;
   logic [MAG_W-1:0]               mag_ff    [NCH][DIV_STAGES];
   logic [MAG_W-1:0]               mag_in    [NCH][DIV_STAGES];
   logic                           neg_ff    [NCH][DIV_STAGES+1];
   logic                           neg_in    [NCH][DIV_STAGES+1];
   logic [7:0]                     radius_ff [NCH][NUM_STAGES];
   logic [7:0]                     radius_in [NCH][NUM_STAGES];
   logic [7:0]                     base_ff   [NCH][NUM_STAGES];
   logic [7:0]                     base_in   [NCH][NUM_STAGES];
   div_state_type                  div_ff    [NCH][DIV_STAGES];
   div_state_type                  div_in    [NCH][DIV_STAGES];
   logic [NCH-1:0][rlsg_pkg::GAIN_W-1:0] gain_ff;
   logic [NCH-1:0][rlsg_pkg::GAIN_W-1:0] gain_in;

   always_comb begin : p_lanes
      logic [7:0]               span;
      logic [8:0]               str_mag;
      logic [16:0]              prod;
      div_state_type            st;
      logic signed [SUM_W-1:0]  q;
      logic signed [SUM_W-1:0]  total;
      valid_in = {valid_ff[NUM_STAGES-2:0], ctrl.valid};
      for (int c = 0; c < NCH; c++) begin
         span    = (shading[c].radius > distance) ? 8'(shading[c].radius - distance)
                                                  : 8'd0;
         str_mag = shading[c].strength[8] ? 9'(-shading[c].strength)
                                          : shading[c].strength;
         prod    = span * str_mag;
         mag_in[c][0]    = prod[MAG_W-1:0];
         neg_in[c][0]    = shading[c].strength[8];
         radius_in[c][0] = shading[c].radius;
         base_in[c][0]   = shading[c].base;
         for (int s = 1; s < DIV_STAGES; s++) begin
            mag_in[c][s] = mag_ff[c][s-1];
         end
         for (int s = 1; s <= DIV_STAGES; s++) begin
            neg_in[c][s] = neg_ff[c][s-1];
         end
         for (int s = 1; s < NUM_STAGES; s++) begin
            radius_in[c][s] = radius_ff[c][s-1];
            base_in[c][s]   = base_ff[c][s-1];
         end
         for (int i = 0; i < DIV_STAGES; i++) begin
            if (i == 0) begin
               st.rem  = {1'b0, mag_ff[c][0][MAG_W-1:QUOT_W]};
               st.quot = '0;
            end else begin
               st = div_ff[c][i-1];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
               st = div_step(st, mag_ff[c][i][QUOT_W-1-(i*DIV_STEPS+j)], radius_ff[c][i]);
            end
            div_in[c][i] = st;
         end
         q = $signed({2'b00, div_ff[c][DIV_STAGES-1].quot});
         if (neg_ff[c][DIV_STAGES]) begin
            q = -q;
         end
         total = $signed({3'b000, base_ff[c][DIV_STAGES]}) + q;
         if (radius_ff[c][DIV_STAGES] == 8'd0) begin
            gain_in[c] = base_ff[c][DIV_STAGES];
         end else if (total < 0) begin
            gain_in[c] = '0;
         end else if (total > $signed({3'b000, rlsg_pkg::GAIN_MAX})) begin
            gain_in[c] = rlsg_pkg::GAIN_MAX;
         end else begin
            gain_in[c] = total[rlsg_pkg::GAIN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl.advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         mag_ff    <= mag_in;
         neg_ff    <= neg_in;
         radius_ff <= radius_in;
         base_ff   <= base_in;
         div_ff    <= div_in;
         gain_ff   <= gain_in;
      end
   end

   assign out_valid = valid_ff[NUM_STAGES-1];
   assign gain      = gain_ff;

   for (genvar c = 0; c < NCH; c++) begin : g_check
      a_rem_below_radius: assert property (@(posedge clock) disable iff (reset)
         valid_ff[DIV_STAGES] && (radius_ff[c][DIV_STAGES] != 8'd0) |->
            div_ff[c][DIV_STAGES-1].rem < radius_ff[c][DIV_STAGES])
         else $error("divider remainder not below radius");

      a_zero_radius_base: assert property (@(posedge clock) disable iff (reset)
         valid_ff[NUM_STAGES-1] && (radius_ff[c][NUM_STAGES-1] == 8'd0) |->
            gain_ff[c] == base_ff[c][NUM_STAGES-1])
         else $error("zero radius gain differs from base");
   end

endmodule
